// ===== hdl/srp_pkg.sv =====
`default_nettype none

package srp_pkg;

    // result kinds
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // characters
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // line layout: three code digits, then the separator slot
    localparam logic [9:0] CODE_DIGITS = 10'd3;
    localparam logic [9:0] SEP_DONE    = 10'd4;

    // line length limit
    localparam logic [10:0] LIM_RST = 11'd512;
    localparam logic [10:0] LIM_MIN = 11'd4;
    localparam logic [10:0] LIM_MAX = 11'd1024;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  text_byte;
        logic [9:0]  reply_code;
        logic [15:0] reply_len;
        logic        last;
    } t_res;

    // beats pushed into the result queue this cycle (0, 1 or 2)
    typedef struct packed {
        logic [1:0] num;
        t_res       beat0;
        t_res       beat1;
    } t_push;

endpackage

`default_nettype wire

// ===== hdl/srp_ifs.sv =====
`default_nettype none

interface srp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface srp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [9:0]  reply_code;
    logic [15:0] reply_len;
    logic        last;
    modport source (output valid, output kind, output text_byte, output reply_code,
                    output reply_len, output last, input ready);
    modport sink   (input valid, input kind, input text_byte, input reply_code,
                    input reply_len, input last, output ready);
endinterface

interface srp_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] max_line_len;
    modport source (output valid, output max_line_len, input ready);
    modport sink   (input valid, input max_line_len, output ready);
endinterface

`default_nettype wire

// ===== hdl/srp_res_fifo.sv =====
`default_nettype none

module srp_res_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  srp_pkg::t_push      i_push,
    output logic                o_room2,
    output logic                o_valid,
    input  wire                 i_ready,
    output srp_pkg::t_res       o_data
);

    srp_pkg::t_res r_mem [srp_pkg::QDEPTH];
    logic [srp_pkg::QAW-1:0] r_wr;
    logic [srp_pkg::QAW-1:0] r_rd;
    logic [srp_pkg::QAW:0]   r_count;
    logic [srp_pkg::QAW-1:0] wr1;
    logic                    pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room2 = (r_count <= (srp_pkg::QAW+1)'(srp_pkg::QDEPTH - 2));
    assign wr1     = r_wr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.beat0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr1] <= i_push.beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + srp_pkg::QAW'(i_push.num);
            r_rd    <= r_rd + srp_pkg::QAW'(pop);
            r_count <= r_count + (srp_pkg::QAW+1)'(i_push.num)
                       - (srp_pkg::QAW+1)'(pop);
        end
    end

    // a double push only lands with two free slots
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num == 2'd2) |-> (r_count <= (srp_pkg::QAW+1)'(srp_pkg::QDEPTH - 2)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== hdl/smtp_reply_parser.sv =====
// SMTP reply parser.
// Channels: i_in carries one reply byte per beat (data_byte). o_out carries
// result beats: kind 0 is a text byte, kind 1 is reply complete with
// reply_code and reply_len, kind 2 is a protocol error. last marks the final
// result beat caused by one input byte. i_cfg writes max_line_len (clamped to
// 4..1024 when written); it is always ready. It must be written only while
// idle, by the user; the block does not enforce it. Throughput: one input
// byte per cycle while i_in is ready. Parsing is done in the cycle a byte is
// accepted; its results are registered in a four-entry result queue and show
// on o_out. The queue drains one beat a cycle while o_out is ready; a byte can
// yield two beats (held CR plus text, or the kept CRLF between lines), so the
// output port bounds the sustained rate. i_in.ready is high while the queue
// has two free slots, so a stalled receiver stops input after at most four
// buffered beats and nothing is lost. Reset (synchronous, active low) clears
// the parse state, empties the queue and sets max_line_len to 512.

`default_nettype none

module smtp_reply_parser (
    input  wire        i_clk,
    input  wire        i_rst_n,
    srp_byte_if.sink   i_in,
    srp_cfg_if.sink    i_cfg,
    srp_res_if.source  o_out
);

    // parse state
    logic [10:0] r_lim;
    logic [9:0]  r_pos,   n_pos;       // bytes taken in current line
    logic [9:0]  r_code,  n_code;      // code digits so far
    logic [9:0]  r_prior, n_prior;     // reply code, 0 = none yet
    logic        r_final, n_final;     // separator was ' '
    logic        r_held,  n_held;      // CR seen, not yet emitted
    logic        r_pending, n_pending; // inter-line CRLF not yet emitted
    logic [15:0] r_total, n_total;     // reply length so far

    srp_pkg::t_push push;
    srp_pkg::t_res  q_data;
    logic           room2;
    logic           accept;
    logic [7:0]     b;
    logic [16:0]    sum;
    logic [15:0]    sat_sum;
    logic [10:0]    pos_inc;
    logic [9:0]     code_nx;
    logic           is_digit;

    function automatic srp_pkg::t_res mk_text(input logic [7:0] ch);
        srp_pkg::t_res r;
        r           = '0;
        r.kind      = srp_pkg::KIND_TEXT;
        r.text_byte = ch;
        return r;
    endfunction

    function automatic srp_pkg::t_res mk_err();
        srp_pkg::t_res r;
        r      = '0;
        r.kind = srp_pkg::KIND_ERR;
        return r;
    endfunction

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = room2;
    assign i_cfg.ready = 1'b1;
    assign b        = i_in.data_byte;
    assign sum      = {1'b0, r_total} + 17'(r_pos) + 17'd1;
    assign sat_sum  = sum[16] ? 16'hFFFF : sum[15:0];
    assign pos_inc  = 11'(r_pos) + 11'd1;
    assign is_digit = (b >= srp_pkg::CH_0) && (b <= srp_pkg::CH_9);
    // code*10 + digit; code stays below 100 before the third digit
    assign code_nx  = (r_code << 3) + (r_code << 1) + 10'(b - srp_pkg::CH_0);

    always_comb begin
        logic fail;
        fail      = 1'b0;
        n_pos     = r_pos;
        n_code    = r_code;
        n_prior   = r_prior;
        n_final   = r_final;
        n_held    = r_held;
        n_pending = r_pending;
        n_total   = r_total;
        push      = '0;

        if (accept) begin
            if (r_held && r_pos < srp_pkg::CODE_DIGITS) begin
                // CR inside the code: short or empty line
                fail = 1'b1;
            end else if (r_held && b == srp_pkg::CH_LF) begin
                if (r_pos == srp_pkg::SEP_DONE || r_final) begin
                    // last line done: report code and length, restart
                    n_pos      = '0;
                    n_code     = '0;
                    n_prior    = '0;
                    n_final    = 1'b0;
                    n_held     = 1'b0;
                    n_pending  = 1'b0;
                    n_total    = '0;
                    push.num   = 2'd1;
                    push.beat0 = '0;
                    push.beat0.kind       = srp_pkg::KIND_DONE;
                    push.beat0.reply_code = r_code;
                    push.beat0.reply_len  = sat_sum;
                end else begin
                    n_total   = sat_sum;
                    n_pending = 1'b1;
                    n_pos     = '0;
                    n_code    = '0;
                    n_held    = 1'b0;
                    n_final   = 1'b0;
                end
            end else if (r_held && r_pos == srp_pkg::SEP_DONE) begin
                // CR in separator slot without LF
                fail = 1'b1;
            end else if (pos_inc >= r_lim) begin
                fail = 1'b1;
            end else if (r_pos < srp_pkg::CODE_DIGITS) begin
                if (b == srp_pkg::CH_CR) begin
                    n_held = 1'b1;
                    n_pos  = r_pos + 10'd1;
                end else if (is_digit) begin
                    n_code = code_nx;
                    n_pos  = r_pos + 10'd1;
                    if (r_pos == srp_pkg::CODE_DIGITS - 10'd1) begin
                        if (r_prior != '0 && code_nx != r_prior) begin
                            fail = 1'b1;
                        end else begin
                            n_prior = code_nx;
                        end
                    end
                end else begin
                    fail = 1'b1;
                end
            end else if (r_pos == srp_pkg::CODE_DIGITS) begin
                if (b == srp_pkg::CH_CR) begin
                    n_held = 1'b1;
                    n_pos  = r_pos + 10'd1;
                end else if (b == srp_pkg::CH_SP || b == srp_pkg::CH_DASH) begin
                    n_final = (b == srp_pkg::CH_SP);
                    if (r_pending) begin
                        // release the CRLF of the previous line
                        push.num   = 2'd2;
                        push.beat0 = mk_text(srp_pkg::CH_CR);
                        push.beat1 = mk_text(srp_pkg::CH_LF);
                        n_pending  = 1'b0;
                    end
                    n_pos = r_pos + 10'd1;
                end else begin
                    fail = 1'b1;
                end
            end else begin
                // text slot; a bare CR goes out ahead of the byte after it
                n_pos = r_pos + 10'd1;
                if (r_held) begin
                    n_held = (b == srp_pkg::CH_CR);
                    if (b == srp_pkg::CH_CR) begin
                        push.num   = 2'd1;
                        push.beat0 = mk_text(srp_pkg::CH_CR);
                    end else begin
                        push.num   = 2'd2;
                        push.beat0 = mk_text(srp_pkg::CH_CR);
                        push.beat1 = mk_text(b);
                    end
                end else if (b == srp_pkg::CH_CR) begin
                    n_held = 1'b1;
                end else begin
                    push.num   = 2'd1;
                    push.beat0 = mk_text(b);
                end
            end

            if (fail) begin
                n_pos      = '0;
                n_code     = '0;
                n_prior    = '0;
                n_final    = 1'b0;
                n_held     = 1'b0;
                n_pending  = 1'b0;
                n_total    = '0;
                push.num   = 2'd1;
                push.beat0 = mk_err();
            end

            if (push.num == 2'd1) begin
                push.beat0.last = 1'b1;
            end else if (push.num == 2'd2) begin
                push.beat1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim     <= srp_pkg::LIM_RST;
            r_pos     <= '0;
            r_code    <= '0;
            r_prior   <= '0;
            r_final   <= 1'b0;
            r_held    <= 1'b0;
            r_pending <= 1'b0;
            r_total   <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.max_line_len < srp_pkg::LIM_MIN) begin
                    r_lim <= srp_pkg::LIM_MIN;
                end else if (i_cfg.max_line_len > srp_pkg::LIM_MAX) begin
                    r_lim <= srp_pkg::LIM_MAX;
                end else begin
                    r_lim <= i_cfg.max_line_len;
                end
            end
            r_pos     <= n_pos;
            r_code    <= n_code;
            r_prior   <= n_prior;
            r_final   <= n_final;
            r_held    <= n_held;
            r_pending <= n_pending;
            r_total   <= n_total;
        end
    end

    srp_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (q_data)
    );

    assign o_out.kind       = q_data.kind;
    assign o_out.text_byte  = q_data.text_byte;
    assign o_out.reply_code = q_data.reply_code;
    assign o_out.reply_len  = q_data.reply_len;
    assign o_out.last       = q_data.last;

    // a held CR is itself counted, so the line position is never zero with it
    a_held_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_pos != '0))
        else $error("held CR with empty line");

    // the last-line flag only exists past the separator slot
    a_final_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final |-> (r_pos >= srp_pkg::SEP_DONE))
        else $error("final flag before separator");

    // an accepted byte either advances the line, wraps it, or reports
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && push.num == 2'd0) |=> (r_pos != $past(r_pos) || r_pending))
        else $error("byte consumed without effect");

endmodule

`default_nettype wire
